// ----- rtl/core/cylinder_flux_interpolator_core_assert.svh -----
// Assertion macros shared by the RTL of the flux interpolator.
// CFI_ASSERT_IMP checks a same-cycle implication, CFI_ASSERT_NXT a next-cycle one.
`ifndef CYLINDER_FLUX_INTERPOLATOR_CORE_ASSERT_SVH
`define CYLINDER_FLUX_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flux interpolator assertion failed");
`define CFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flux interpolator assertion failed");
`else
`define CFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/cfi_pkg.sv -----
package cfi_pkg;

    localparam int NCOEF        = 5;
    localparam int CORDIC_STEPS = 20;
    localparam int FRAC_BITS    = 24;
    localparam int SEG_W        = 8;
    localparam int ANG_LAT      = 43;
    localparam int AXIS_LAT     = 29;
    localparam int VEC_W        = 60;
    localparam int ROT_W        = 34;

    localparam logic signed [ROT_W-1:0] CORDIC_KQ30 = 34'sd652032874;

    typedef logic signed [ROT_W-1:0] trig_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        CFG_BOTTOM_X      = 3'd0,
        CFG_BOTTOM_Y      = 3'd1,
        CFG_BOTTOM_Z      = 3'd2,
        CFG_TOP_X         = 3'd3,
        CFG_TOP_Y         = 3'd4,
        CFG_TOP_Z         = 3'd5,
        CFG_STATION_COUNT = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PROJ_BELOW  = 2'd0,
        PROJ_TOP    = 2'd1,
        PROJ_INSIDE = 2'd2
    } proj_t;

    typedef struct packed {
        logic [SEG_W-1:0]     slo;
        logic [SEG_W-1:0]     shi;
        logic [FRAC_BITS-1:0] w;
        logic                 outside;
    } seg_t;

    // Binary-angle arctangent table, 2^32 is one full turn.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/cfi_angle.sv -----
module cfi_angle
    import cfi_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    output trig_t              cos1,
    output trig_t              sin1,
    output trig_t              cos2,
    output trig_t              sin2
);

    // Vectoring chain: index 0 holds the pre-rotated point.
    logic signed [VEC_W-1:0] vx_reg [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] vy_reg [0:CORDIC_STEPS];
    logic [31:0]             vz_reg [0:CORDIC_STEPS];
    logic                    vzero_reg [0:CORDIC_STEPS];

    logic signed [VEC_W-1:0] vx_next, vy_next, x0, y0;
    logic [31:0]             vz_next;

    // Rotation chains: channel 0 for theta, channel 1 for twice theta.
    logic signed [ROT_W-1:0] rx_reg [0:1][0:CORDIC_STEPS];
    logic signed [ROT_W-1:0] ry_reg [0:1][0:CORDIC_STEPS];
    logic signed [ROT_W-1:0] rz_reg [0:1][0:CORDIC_STEPS];
    logic                    rneg_reg [0:1][0:CORDIC_STEPS];
    trig_t                   tc_reg [0:1];
    trig_t                   ts_reg [0:1];

    logic [31:0] ang [0:1];

    function automatic logic [ROT_W:0] fold(input logic [31:0] a);
        logic signed [ROT_W-1:0] z;
        logic                    neg;
        z   = $signed({{(ROT_W-32){a[31]}}, a});
        neg = 1'b0;
        if (z > 34'sh040000000) begin
            z   = z - 34'sh080000000;
            neg = 1'b1;
        end else if (z < -34'sh040000000) begin
            z   = z + 34'sh080000000;
            neg = 1'b1;
        end
        return {neg, z};
    endfunction

    assign x0 = $signed({{(VEC_W-56){x_in[31]}}, x_in, 24'b0});
    assign y0 = $signed({{(VEC_W-56){y_in[31]}}, y_in, 24'b0});

    // Bring the vector into the right half plane before the iterations.
    always_comb begin
        vx_next = x0;
        vy_next = y0;
        vz_next = 32'h0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                vx_next = y0;
                vy_next = -x0;
                vz_next = 32'h40000000;
            end else begin
                vx_next = -y0;
                vy_next = x0;
                vz_next = 32'hC0000000;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg[0]    <= vx_next;
            vy_reg[0]    <= vy_next;
            vz_reg[0]    <= vz_next;
            vzero_reg[0] <= (x_in == 32'sd0) && (y_in == 32'sd0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (en) begin
                if (vy_reg[i] > 0) begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + atan_entry(5'(i));
                end else begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - atan_entry(5'(i));
                end
                vzero_reg[i+1] <= vzero_reg[i];
            end
        end
    end

    // A point at the origin has angle zero.
    assign ang[0] = vzero_reg[CORDIC_STEPS] ? 32'h0 : vz_reg[CORDIC_STEPS];
    assign ang[1] = {ang[0][30:0], 1'b0};

    for (genvar ch = 0; ch < 2; ch++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (en) begin
                {rneg_reg[ch][0], rz_reg[ch][0]} <= fold(ang[ch]);
                rx_reg[ch][0] <= CORDIC_KQ30;
                ry_reg[ch][0] <= '0;
            end
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (rz_reg[ch][i] >= 0) begin
                        rx_reg[ch][i+1] <= rx_reg[ch][i] - (ry_reg[ch][i] >>> i);
                        ry_reg[ch][i+1] <= ry_reg[ch][i] + (rx_reg[ch][i] >>> i);
                        rz_reg[ch][i+1] <= rz_reg[ch][i]
                                           - $signed({2'b00, atan_entry(5'(i))});
                    end else begin
                        rx_reg[ch][i+1] <= rx_reg[ch][i] + (ry_reg[ch][i] >>> i);
                        ry_reg[ch][i+1] <= ry_reg[ch][i] - (rx_reg[ch][i] >>> i);
                        rz_reg[ch][i+1] <= rz_reg[ch][i]
                                           + $signed({2'b00, atan_entry(5'(i))});
                    end
                    rneg_reg[ch][i+1] <= rneg_reg[ch][i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tc_reg[ch] <= rneg_reg[ch][CORDIC_STEPS] ? -rx_reg[ch][CORDIC_STEPS]
                                                         : rx_reg[ch][CORDIC_STEPS];
                ts_reg[ch] <= rneg_reg[ch][CORDIC_STEPS] ? -ry_reg[ch][CORDIC_STEPS]
                                                         : ry_reg[ch][CORDIC_STEPS];
            end
        end
    end

    assign cos1 = tc_reg[0];
    assign sin1 = ts_reg[0];
    assign cos2 = tc_reg[1];
    assign sin2 = ts_reg[1];

endmodule

// ----- rtl/core/cfi_axis.sv -----
module cfi_axis
    import cfi_pkg::*;
#(
    parameter int MAX_STATIONS = 16
)
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] point [3],
    input  logic signed [31:0] bottom [3],
    input  logic signed [31:0] top [3],
    input  logic [4:0]         station_count,
    output seg_t               seg
);

    localparam int DIV_N = FRAC_BITS;
    localparam int U_W   = SEG_W + FRAC_BITS;

    logic signed [32:0] a_reg [3];
    logic signed [32:0] p_reg [3];
    logic [SEG_W-1:0]   nm1_next;
    logic [SEG_W-1:0]   nm1_reg [0:DIV_N+3];

    logic signed [28:0] as_reg [3];
    logic signed [28:0] ps_reg [3];
    logic signed [28:0] as_next [3];
    logic signed [28:0] ps_next [3];
    logic signed [32:0] a_sh [3];
    logic signed [32:0] p_sh [3];
    logic [2:0]         sa_next, sp_next;
    logic [2:0]         sa_reg [0:1];
    logic [2:0]         sp_reg [0:1];

    logic signed [57:0] dp_reg [3];
    logic signed [57:0] aq_reg [3];

    logic signed [59:0] dot, aa;
    logic signed [63:0] num;
    logic [63:0]        den;
    proj_t              mode_next;
    logic               out_next;

    logic [63:0]          r_reg [0:DIV_N];
    logic [FRAC_BITS-1:0] f_reg [0:DIV_N];
    logic [63:0]          d_reg [0:DIV_N];
    proj_t                mode_reg [0:DIV_N];
    logic                 out_reg [0:DIV_N];

    logic [U_W-1:0] u;
    seg_t           seg_next, seg_reg;

    function automatic logic fits(input logic signed [32:0] v, input int s);
        logic signed [33:0] lim;
        logic signed [33:0] ve;
        lim = 34'sd1 <<< (28 + s);
        ve  = $signed({v[32], v});
        return (ve >= -lim) && (ve < lim);
    endfunction

    // Smallest right shift that brings all three components into 29 bits.
    function automatic logic [2:0] fit_shift(input logic signed [32:0] v0,
                                             input logic signed [32:0] v1,
                                             input logic signed [32:0] v2);
        logic [2:0] s;
        s = 3'd5;
        for (int k = 4; k >= 0; k--) begin
            if (fits(v0, k) && fits(v1, k) && fits(v2, k)) begin
                s = 3'(k);
            end
        end
        return s;
    endfunction

    always_comb begin
        if (station_count < 5'd2) begin
            nm1_next = SEG_W'(1);
        end else if (int'(station_count) > MAX_STATIONS) begin
            nm1_next = SEG_W'(MAX_STATIONS - 1);
        end else begin
            nm1_next = SEG_W'(station_count) - SEG_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a_reg[k] <= $signed({top[k][31], top[k]}) - $signed({bottom[k][31], bottom[k]});
                p_reg[k] <= $signed({point[k][31], point[k]})
                            - $signed({bottom[k][31], bottom[k]});
            end
            nm1_reg[0] <= nm1_next;
            for (int k = 1; k < DIV_N + 4; k++) begin
                nm1_reg[k] <= nm1_reg[k-1];
            end
        end
    end

    assign sa_next = fit_shift(a_reg[0], a_reg[1], a_reg[2]);
    assign sp_next = fit_shift(p_reg[0], p_reg[1], p_reg[2]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_sh[k]    = a_reg[k] >>> sa_next;
            p_sh[k]    = p_reg[k] >>> sp_next;
            as_next[k] = a_sh[k][28:0];
            ps_next[k] = p_sh[k][28:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            as_reg    <= as_next;
            ps_reg    <= ps_next;
            sa_reg[0] <= sa_next;
            sp_reg[0] <= sp_next;
            sa_reg[1] <= sa_reg[0];
            sp_reg[1] <= sp_reg[0];
            for (int k = 0; k < 3; k++) begin
                dp_reg[k] <= as_reg[k] * ps_reg[k];
                aq_reg[k] <= as_reg[k] * as_reg[k];
            end
        end
    end

    always_comb begin
        dot = 60'(dp_reg[0]) + 60'(dp_reg[1]) + 60'(dp_reg[2]);
        aa  = 60'(aq_reg[0]) + 60'(aq_reg[1]) + 60'(aq_reg[2]);
        num = 64'(dot) <<< sp_reg[1];
        den = 64'(unsigned'(aa)) << sa_reg[1];
        out_next = 1'b0;
        if (den == 64'd0 || num < 0) begin
            mode_next = PROJ_BELOW;
            out_next  = 1'b1;
        end else if (unsigned'(num) >= den) begin
            mode_next = PROJ_TOP;
            out_next  = unsigned'(num) > den;
        end else begin
            mode_next = PROJ_INSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]    <= unsigned'(num);
            f_reg[0]    <= '0;
            d_reg[0]    <= den;
            mode_reg[0] <= mode_next;
            out_reg[0]  <= out_next;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar i = 0; i < DIV_N; i++) begin : g_div
        logic [63:0] r2;
        assign r2 = {r_reg[i][62:0], 1'b0};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (r2 >= d_reg[i]) begin
                    r_reg[i+1] <= r2 - d_reg[i];
                    f_reg[i+1] <= {f_reg[i][FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_reg[i+1] <= r2;
                    f_reg[i+1] <= {f_reg[i][FRAC_BITS-2:0], 1'b0};
                end
                d_reg[i+1]    <= d_reg[i];
                mode_reg[i+1] <= mode_reg[i];
                out_reg[i+1]  <= out_reg[i];
            end
        end
    end

    assign u = U_W'(nm1_reg[DIV_N+3]) * U_W'(f_reg[DIV_N]);

    always_comb begin
        seg_next = '0;
        case (mode_reg[DIV_N])
            PROJ_BELOW: begin
                seg_next.outside = 1'b1;
            end
            PROJ_TOP: begin
                seg_next.slo     = nm1_reg[DIV_N+3];
                seg_next.shi     = nm1_reg[DIV_N+3];
                seg_next.outside = out_reg[DIV_N];
            end
            PROJ_INSIDE: begin
                seg_next.slo = u[U_W-1 -: SEG_W];
                seg_next.w   = u[FRAC_BITS-1:0];
                seg_next.shi = (u[FRAC_BITS-1:0] == '0) ? u[U_W-1 -: SEG_W]
                                                        : u[U_W-1 -: SEG_W] + SEG_W'(1);
            end
            default: begin
                seg_next.outside = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seg_reg <= seg_next;
        end
    end

    assign seg = seg_reg;

endmodule

// ----- rtl/core/cylinder_flux_interpolator_core.sv -----
// Channel   | Direction | Ports                        | Contents
// ----------+-----------+------------------------------+----------------------------------
// s_ stream | in        | s_tvalid s_tready s_tdata    | load of one coefficient or a
//           |           | s_tuser                      | query point
// m_ stream | out       | m_tvalid m_tready m_tdata    | one result per query item
// cfg       | in        | cfg_wr_en cfg_addr           | axis end points, station count
//           |           | cfg_wr_data                  |
//
// One item enters every cycle unless a waiting result holds the pipeline.
// The depth is set by the two 20-step CORDIC chains (angle, then cos and sin) run in
// series, with the 24-step projection divider running beside them.
// Reset clears the valid bits and the configuration registers. The coefficient table is
// not cleared, and an entry holds no defined value until a load writes it.
// When a result waits at the output, the whole pipeline holds; the next item is taken in
// the same cycle in which the waiting result is taken.
`include "cylinder_flux_interpolator_core_assert.svh"

module cylinder_flux_interpolator_core
    import cfi_pkg::*;
#(
    parameter int MAX_STATIONS = 16
)
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // station[3:0], coeff_index[6:4], coeff_value[38:7], point_x[70:39],
    // point_y[102:71], point_z[134:103], zero fill[135]
    input  logic [135:0] s_tdata,
    // req_type[0]
    input  logic [0:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // flux_value[31:0], negative_warning[32], outside_axis[33], zero fill[39:34]
    output logic [39:0]  m_tdata,

    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wr_data
);

    localparam int SW = (MAX_STATIONS > 2) ? $clog2(MAX_STATIONS) : 1;
    localparam int PAD = ANG_LAT - AXIS_LAT;

    // Configuration registers.
    logic signed [31:0] bottom_reg [3];
    logic signed [31:0] top_reg [3];
    logic [4:0]         count_reg;

    // Global pipeline advance: every stage moves when the output slot is free or taken.
    logic en;

    // Item fields carried alongside the angle and projection units.
    logic        vld_reg [1:ANG_LAT];
    req_t        typ_reg [1:ANG_LAT];
    logic [3:0]  sta_reg [1:ANG_LAT];
    logic [2:0]  ci_reg [1:ANG_LAT];
    logic [31:0] cv_reg [1:ANG_LAT];

    logic signed [31:0] point [3];
    trig_t              cos1, sin1, cos2, sin2;
    seg_t               seg_ax;
    seg_t               seg_pad_reg [1:PAD];
    seg_t               seg_s;

    logic q43, ld43, we;
    logic [SW-1:0] st_idx;

    // Stage 44: table read data and trig values.
    logic signed [31:0] rlo_reg [NCOEF];
    logic signed [31:0] rhi_reg [NCOEF];
    trig_t              trig_reg [4];
    logic [FRAC_BITS-1:0] w44_reg, w45_reg, w46_reg;
    logic               o44_reg, o45_reg, o46_reg, o47_reg;
    logic               v44_reg, v45_reg, v46_reg, v47_reg;

    // Stage 45: products of coefficients and trig values.
    logic signed [65:0] plo_reg [4];
    logic signed [65:0] phi_reg [4];
    logic signed [31:0] c0lo_reg, c0hi_reg;

    // Stage 46: series value at each bracketing station.
    logic signed [37:0] slo_next, shi_next, slo_reg, shi_reg;

    // Stage 47: weighted difference.
    logic signed [38:0] diff;
    logic signed [63:0] pw_reg;
    logic signed [37:0] lo47_reg;
    logic               neg47_reg;

    // Output register.
    logic signed [63:0] rnd;
    logic signed [39:0] step;
    logic signed [40:0] sum;
    logic [31:0]        flux;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bottom_reg[0] <= '0;
            bottom_reg[1] <= '0;
            bottom_reg[2] <= '0;
            top_reg[0]    <= '0;
            top_reg[1]    <= '0;
            top_reg[2]    <= 32'sd65536;
            count_reg     <= 5'd2;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_BOTTOM_X:      bottom_reg[0] <= cfg_wr_data;
                CFG_BOTTOM_Y:      bottom_reg[1] <= cfg_wr_data;
                CFG_BOTTOM_Z:      bottom_reg[2] <= cfg_wr_data;
                CFG_TOP_X:         top_reg[0]    <= cfg_wr_data;
                CFG_TOP_Y:         top_reg[1]    <= cfg_wr_data;
                CFG_TOP_Z:         top_reg[2]    <= cfg_wr_data;
                CFG_STATION_COUNT: count_reg     <= cfg_wr_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign point[0] = s_tdata[70:39];
    assign point[1] = s_tdata[102:71];
    assign point[2] = s_tdata[134:103];

    // Valid bits for every stage up to the table access.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= ANG_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= ANG_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            typ_reg[1] <= req_t'(s_tuser[0]);
            sta_reg[1] <= s_tdata[3:0];
            ci_reg[1]  <= s_tdata[6:4];
            cv_reg[1]  <= s_tdata[38:7];
            for (int k = 2; k <= ANG_LAT; k++) begin
                typ_reg[k] <= typ_reg[k-1];
                sta_reg[k] <= sta_reg[k-1];
                ci_reg[k]  <= ci_reg[k-1];
                cv_reg[k]  <= cv_reg[k-1];
            end
        end
    end

    cfi_angle u_angle (
        .aclk (aclk),
        .en   (en),
        .x_in (point[0]),
        .y_in (point[1]),
        .cos1 (cos1),
        .sin1 (sin1),
        .cos2 (cos2),
        .sin2 (sin2)
    );

    cfi_axis #(
        .MAX_STATIONS (MAX_STATIONS)
    ) u_axis (
        .aclk          (aclk),
        .en            (en),
        .point         (point),
        .bottom        (bottom_reg),
        .top           (top_reg),
        .station_count (count_reg),
        .seg           (seg_ax)
    );

    // The projection finishes before the angle; hold its result until the two line up.
    always_ff @(posedge aclk) begin
        if (en) begin
            seg_pad_reg[1] <= seg_ax;
            for (int k = 2; k <= PAD; k++) begin
                seg_pad_reg[k] <= seg_pad_reg[k-1];
            end
        end
    end

    assign seg_s = seg_pad_reg[PAD];

    // Loads write the table at the same stage where queries read it, so every item sees
    // exactly the writes of the loads taken before it.
    assign q43    = vld_reg[ANG_LAT] && (typ_reg[ANG_LAT] == REQ_QUERY);
    assign ld43   = vld_reg[ANG_LAT] && (typ_reg[ANG_LAT] == REQ_LOAD);
    assign we     = en && ld43 && (int'(sta_reg[ANG_LAT]) < MAX_STATIONS)
                    && (int'(ci_reg[ANG_LAT]) < NCOEF);
    assign st_idx = SW'(sta_reg[ANG_LAT]);

    for (genvar c = 0; c < NCOEF; c++) begin : g_bank
        logic [31:0] mem [MAX_STATIONS];
        always_ff @(posedge aclk) begin
            if (we && (ci_reg[ANG_LAT] == 3'(c))) begin
                mem[st_idx] <= cv_reg[ANG_LAT];
            end
            if (en) begin
                rlo_reg[c] <= mem[seg_s.slo[SW-1:0]];
                rhi_reg[c] <= mem[seg_s.shi[SW-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v44_reg <= 1'b0;
            v45_reg <= 1'b0;
            v46_reg <= 1'b0;
            v47_reg <= 1'b0;
        end else if (en) begin
            v44_reg <= q43;
            v45_reg <= v44_reg;
            v46_reg <= v45_reg;
            v47_reg <= v46_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg[0] <= cos1;
            trig_reg[1] <= sin1;
            trig_reg[2] <= cos2;
            trig_reg[3] <= sin2;
            w44_reg     <= seg_s.w;
            o44_reg     <= seg_s.outside;

            for (int j = 0; j < 4; j++) begin
                plo_reg[j] <= rlo_reg[j+1] * trig_reg[j];
                phi_reg[j] <= rhi_reg[j+1] * trig_reg[j];
            end
            c0lo_reg <= rlo_reg[0];
            c0hi_reg <= rhi_reg[0];
            w45_reg  <= w44_reg;
            o45_reg  <= o44_reg;

            slo_reg <= slo_next;
            shi_reg <= shi_next;
            w46_reg <= w45_reg;
            o46_reg <= o45_reg;

            pw_reg    <= diff * $signed({1'b0, w46_reg});
            lo47_reg  <= slo_reg;
            neg47_reg <= (slo_reg < 0) || (shi_reg < 0);
            o47_reg   <= o46_reg;
        end
    end

    // Each of the four trig terms is rounded to Q16.16 before the five are summed.
    always_comb begin
        logic signed [65:0] tl, th;
        slo_next = 38'(c0lo_reg);
        shi_next = 38'(c0hi_reg);
        for (int j = 0; j < 4; j++) begin
            tl = (plo_reg[j] + 66'sd536870912) >>> 30;
            th = (phi_reg[j] + 66'sd536870912) >>> 30;
            slo_next = slo_next + 38'(tl);
            shi_next = shi_next + 38'(th);
        end
    end

    assign diff = 39'(shi_reg) - 39'(slo_reg);

    always_comb begin
        rnd  = (pw_reg + 64'sd8388608) >>> FRAC_BITS;
        step = rnd[39:0];
        sum  = 41'(lo47_reg) + 41'(step);
        if (sum > 41'sd2147483647) begin
            flux = 32'h7FFFFFFF;
        end else if (sum < -41'sd2147483648) begin
            flux = 32'h80000000;
        end else begin
            flux = sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v47_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {6'b0, o47_reg, neg47_reg, flux};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CFI_ASSERT_IMP(a_seg_span, aclk, aresetn, q43, (seg_s.shi == seg_s.slo) || (seg_s.shi == seg_s.slo + 8'd1))
    `CFI_ASSERT_IMP(a_seg_frac, aclk, aresetn, q43 && (seg_s.w != '0), seg_s.shi == seg_s.slo + 8'd1)
    `CFI_ASSERT_IMP(a_seg_range, aclk, aresetn, q43, int'(seg_s.shi) < MAX_STATIONS)
    `CFI_ASSERT_NXT(a_out_follow, aclk, aresetn, en && v47_reg, m_tvalid)
    `CFI_ASSERT_NXT(a_hold_stall, aclk, aresetn, !en, $stable(vld_reg[ANG_LAT]) && $stable(v47_reg))

endmodule

// ----- test/cfi_checker.sv -----
`timescale 1ns / 100ps

// Watches the query and result channels of the flux interpolator, keeps its own copy
// of the axis registers and coefficient table, predicts each query's result and
// compares it with what leaves the block, oldest first.
module cfi_checker
    import cfi_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wr_data,
    output int           fail_count,
    output int           outstanding
);

    typedef struct {
        logic [31:0] flux;
        logic        neg_warn;
        logic        outside;
    } flux_result_t;

    localparam int STATIONS = 16;
    localparam longint LIMIT = 64'sd268435456;

    flux_result_t  flux_queue[$];
    longint        ax0, ay0, az0, ax1, ay1, az1;
    logic [4:0]    n_stations;
    longint        coef_table[STATIONS*NCOEF];

    function automatic logic [31:0] point_angle(input longint x, input longint y);
        longint      vx, vy, t;
        logic [31:0] z;
        vx = x * 64'sd16777216;
        vy = y * 64'sd16777216;
        z  = 32'h0;
        if (x == 0 && y == 0) return 32'h0;
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy; vy = -t; z = 32'h40000000;
            end else begin
                vx = -vy; vy = t; z = 32'hC0000000;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (vy > 0) begin
                t = vx + (vy >>> i); vy = vy - (vx >>> i); z = z + atan_entry(5'(i));
            end else begin
                t = vx - (vy >>> i); vy = vy + (vx >>> i); z = z - atan_entry(5'(i));
            end
            vx = t;
        end
        return z;
    endfunction

    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        longint z, x, y, t;
        bit     flip;
        z = longint'($signed(ang));
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > 64'sh40000000) begin
            z = z - 64'sh80000000; flip = 1;
        end else if (z < -64'sh40000000) begin
            z = z + 64'sh80000000; flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); z = z - atan_entry(5'(i));
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); z = z + atan_entry(5'(i));
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint station_value(input int st, input longint trig[4]);
        longint acc;
        acc = coef_table[st*NCOEF];
        for (int k = 0; k < 4; k++)
            acc += (coef_table[st*NCOEF+k+1] * trig[k] + (64'sd1 <<< 29)) >>> 30;
        return acc;
    endfunction

    // Smallest right shift, at most 5, that brings every component into range.
    function automatic int fit_shift(input longint v0, input longint v1, input longint v2);
        for (int s = 0; s < 5; s++) begin
            if ((v0 >>> s) >= -LIMIT && (v0 >>> s) < LIMIT &&
                (v1 >>> s) >= -LIMIT && (v1 >>> s) < LIMIT &&
                (v2 >>> s) >= -LIMIT && (v2 >>> s) < LIMIT)
                return s;
        end
        return 5;
    endfunction

    task automatic predict_query(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz, output flux_result_t r);
        longint a[3], p[3], trig[4], dot, aa, num, den, lo, hi, v, w, u;
        longint unsigned rem, frac;
        int n, sa, sp, slo, shi;
        logic [31:0] ang;
        n = n_stations < 2 ? 2 : (n_stations > STATIONS ? STATIONS : int'(n_stations));
        a[0] = ax1 - ax0; a[1] = ay1 - ay0; a[2] = az1 - az0;
        p[0] = longint'($signed(px)) - ax0;
        p[1] = longint'($signed(py)) - ay0;
        p[2] = longint'($signed(pz)) - az0;
        sa = fit_shift(a[0], a[1], a[2]);
        sp = fit_shift(p[0], p[1], p[2]);
        dot = 0;
        aa = 0;
        for (int k = 0; k < 3; k++) begin
            dot += (a[k] >>> sa) * (p[k] >>> sp);
            aa  += (a[k] >>> sa) * (a[k] >>> sa);
        end
        num = dot <<< sp;
        den = aa <<< sa;
        slo = 0; shi = 0; w = 0; r.outside = 0;
        if (den == 0 || num < 0) begin
            r.outside = 1;
        end else if (num >= den) begin
            slo = n - 1;
            shi = n - 1;
            r.outside = (num > den);
        end else begin
            // Restoring division for the fraction of the way along the axis.
            rem = num;
            frac = 0;
            for (int k = 0; k < FRAC_BITS; k++) begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= longint'(den)) begin
                    rem = rem - den;
                    frac = frac | 1;
                end
            end
            u = longint'(n - 1) * longint'(frac);
            slo = int'(u >>> FRAC_BITS);
            w = u & ((64'sd1 <<< FRAC_BITS) - 1);
            shi = (w == 0) ? slo : slo + 1;
        end
        ang = point_angle(longint'($signed(px)), longint'($signed(py)));
        rotate(ang, trig[0], trig[1]);
        rotate(ang * 2, trig[2], trig[3]);
        lo = station_value(slo, trig);
        hi = station_value(shi, trig);
        v = lo + (((hi - lo) * w + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.flux = v[31:0];
        r.neg_warn = (lo < 0 || hi < 0);
    endtask

    always @(posedge aclk) begin
        flux_result_t want, got;
        int errs;
        errs = 0;
        if (!aresetn) begin
            ax0 <= 0; ay0 <= 0; az0 <= 0;
            ax1 <= 0; ay1 <= 0; az1 <= 64'sd65536;
            n_stations <= 5'd2;
            fail_count <= 0;
            flux_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    CFG_BOTTOM_X:      ax0 <= longint'($signed(cfg_wr_data));
                    CFG_BOTTOM_Y:      ay0 <= longint'($signed(cfg_wr_data));
                    CFG_BOTTOM_Z:      az0 <= longint'($signed(cfg_wr_data));
                    CFG_TOP_X:         ax1 <= longint'($signed(cfg_wr_data));
                    CFG_TOP_Y:         ay1 <= longint'($signed(cfg_wr_data));
                    CFG_TOP_Z:         az1 <= longint'($signed(cfg_wr_data));
                    CFG_STATION_COUNT: n_stations <= cfg_wr_data[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (req_t'(s_tuser[0]) == REQ_LOAD) begin
                    if (s_tdata[6:4] < NCOEF)
                        coef_table[s_tdata[3:0]*NCOEF + s_tdata[6:4]] =
                            longint'($signed(s_tdata[38:7]));
                end else begin
                    predict_query(s_tdata[70:39], s_tdata[102:71], s_tdata[134:103], want);
                    flux_queue.insert(flux_queue.size(), want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.flux = m_tdata[31:0];
                got.neg_warn = m_tdata[32];
                got.outside = m_tdata[33];
                if (flux_queue.size() == 0) begin
                    $error("result with no query pending: flux_value %h", got.flux);
                    errs++;
                end else begin
                    want = flux_queue.pop_front();
                    if (got.flux !== want.flux) begin
                        $error("flux_value: expected %h, got %h", want.flux, got.flux);
                        errs++;
                    end
                    if (got.neg_warn !== want.neg_warn) begin
                        $error("negative_warning: expected %b, got %b",
                               want.neg_warn, got.neg_warn);
                        errs++;
                    end
                    if (got.outside !== want.outside) begin
                        $error("outside_axis: expected %b, got %b", want.outside, got.outside);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
        outstanding <= flux_queue.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

// Stimulus for the flux interpolator. The top drives loads, queries and register
// writes; the checker beside the block does all the predicting and comparing and
// hands back its failure count.
module tb
    import cfi_pkg::*;
;

    // The settle time is longer than the pipeline is deep, so it covers any load or
    // query still in flight when the last result has come out.
    localparam int SETTLE    = 64;
    localparam int MAX_CYCLE = 600000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [39:0]  m_tdata;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wr_data = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int burst_left = 0;

    // The test keeps its own view of the axis so that it can aim points along it.
    longint axis_lo[3] = '{0, 0, 0};
    longint axis_hi[3] = '{0, 0, 65536};
    int     n_used = 2;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    cylinder_flux_interpolator_core uut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_addr, .cfg_wr_data
    );

    cfi_checker u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_wr_en, .cfg_addr, .cfg_wr_data,
        .fail_count, .outstanding
    );

    // The receiver moves through four stall patterns in turn: always ready,
    // coin toss, a fixed short rhythm, or mostly ready.
    always @(posedge aclk) begin
        int mode;
        cycle_count <= cycle_count + 1;
        mode = (cycle_count / 300) % 4;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(1, 0));
            2: m_tready <= (cycle_count % 7) >= 3;
            default: m_tready <= $urandom_range(9, 0) != 0;
        endcase
        if (cycle_count > MAX_CYCLE) begin
            $display("FAIL");
            $finish;
        end
    end

    // Hands one item to the block. Items go out in bursts; between most bursts the valid
    // line drops for a random number of cycles.
    task automatic send_item(input req_t kind, input logic [135:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(4, 0) == 0 ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(3, 0) == 0 ? $urandom_range(60, 20)
                                                   : $urandom_range(8, 1);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic load_coef(input logic [3:0] st, input logic [2:0] ci, input logic [31:0] v);
        send_item(REQ_LOAD, {97'b0, v, ci, st});
    endtask

    task automatic query(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
        send_item(REQ_QUERY, {1'b0, pz, py, px, 32'b0, 7'b0});
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(5, 0))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(131072, 0) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // Registers are only touched with the pipeline drained and quiet.
    task automatic set_axis(input longint lo[3], input longint hi[3], input int count);
        logic [31:0] vals[7];
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        vals = '{lo[0][31:0], lo[1][31:0], lo[2][31:0],
                 hi[0][31:0], hi[1][31:0], hi[2][31:0], 32'(count)};
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= cfg_reg_t'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        for (int k = 0; k < 3; k++) begin
            axis_lo[k] = longint'($signed(lo[k][31:0]));
            axis_hi[k] = longint'($signed(hi[k][31:0]));
        end
        n_used = count < 2 ? 2 : (count > 16 ? 16 : count);
    endtask

    // Some items load coefficients; most are queries at points along the axis, a little
    // before and past its ends and off to the side, the rest anywhere. Some aim at a station.
    task automatic random_item();
        longint t, pt[3];
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 12) begin
            load_coef(4'($urandom), 3'($urandom_range(4, 0)), any_word());
        end else if (pick < 14) begin
            // A slot past the last coefficient is ignored by the block.
            load_coef(4'($urandom), 3'($urandom_range(7, 5)), $urandom);
        end else if (pick < 74) begin
            t = longint'($urandom_range(1230, 0)) - 100;
            if (pick < 24)
                t = longint'($urandom_range(n_used - 1, 0)) * 1024 / (n_used - 1);
            for (int k = 0; k < 3; k++)
                pt[k] = axis_lo[k] + (((axis_hi[k] - axis_lo[k]) * t) >>> 10)
                        + (pick < 50 ? longint'($signed($urandom_range(65535, 0) - 32768))
                                     : 0);
            query(clip32(pt[0]), clip32(pt[1]), clip32(pt[2]));
        end else begin
            query(any_word(), any_word(), any_word());
        end
    endtask

    initial begin
        longint lo[3], hi[3];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every table entry is written before any query can read it.
        for (int st = 0; st < 16; st++)
            for (int ci = 0; ci < NCOEF; ci++)
                load_coef(4'(st), 3'(ci), any_word());

        // Reset axis runs from the origin to z = 1.0 with two stations.
        query(32'h0, 32'h0, 32'h00008000);
        query(32'h0, 32'h0, 32'hFFFF0000);
        query(32'h00010000, 32'h0, 32'h00020000);
        query(32'h0, 32'h00010000, 32'h00010000);
        query(32'hFFFF0000, 32'h0, 32'h0);
        query(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        query(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        query(32'h0, 32'hFFFF0000, 32'h0000C000);
        load_coef(4'd3, 3'd5, 32'hDEADBEEF);
        load_coef(4'd15, 3'd7, 32'h12345678);
        load_coef(4'd15, 3'd4, 32'h7FFFFFFF);
        load_coef(4'd0, 3'd0, 32'h80000000);
        query(32'h00010000, 32'h00010000, 32'h00004000);

        // Five stations one unit apart: points off to the side, level with each station.
        lo = '{0, 0, 0};
        hi = '{0, 0, 4 * 65536};
        set_axis(lo, hi, 5);
        for (int k = 0; k < 5; k++)
            query(32'h00020000, 32'hFFFF8000, 32'(k * 65536));

        // Top equals bottom: nothing to project onto.
        lo = '{65536, -65536, 12345};
        set_axis(lo, lo, 16);
        query(32'h00010000, 32'h0, 32'h0);
        query(32'h0, 32'h0, 32'h00003039);

        // Widest possible axis, station count above the maximum.
        lo = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
        hi = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
        set_axis(lo, hi, 31);
        repeat (120) random_item();

        // Station count below the minimum, flipped axis.
        set_axis(hi, lo, 0);
        repeat (120) random_item();

        for (int phase = 0; phase < 8; phase++) begin
            for (int k = 0; k < 3; k++) begin
                if (phase % 3 == 0) begin
                    lo[k] = longint'($signed($urandom));
                    hi[k] = longint'($signed($urandom));
                end else begin
                    lo[k] = longint'($urandom_range(1 << 22, 0)) - (1 << 21);
                    hi[k] = longint'($urandom_range(1 << 22, 0)) - (1 << 21);
                end
            end
            set_axis(lo, hi, phase == 7 ? 1 : $urandom_range(16, 2));
            repeat (200) random_item();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cfi_pkg.sv
rtl/core/cfi_angle.sv
rtl/core/cfi_axis.sv
rtl/core/cylinder_flux_interpolator_core.sv
test/cfi_checker.sv
test/tb.sv
